@@ hdl/assert_macros.svh @@
// Assertion macros shared by the decoder RTL; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge
`define U8D_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// cons must hold in the same cycle as ante
`define U8D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// cons must hold in the cycle after ante
`define U8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/u8d_pkg.sv @@
// Package: types, constants and lookup tables of the UTF-8 stream decoder.
`default_nettype none
package u8d_pkg;

  localparam int BYTE_W      = 8;
  localparam int CLASS_W     = 4;
  localparam int STATE_W     = 4;
  localparam int CODE_W      = 21;
  localparam int TRAIL_W     = 6;
  localparam int STATE_COUNT = 9;
  localparam int CLASS_COUNT = 16;
  localparam int ROM_DEPTH   = STATE_COUNT * CLASS_COUNT;
  localparam int ROM_IDX_W   = $clog2(ROM_DEPTH);

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [STATE_W-1:0] ST_ACCEPT = STATE_W'(0);
  localparam logic [STATE_W-1:0] ST_REJECT = STATE_W'(1);

  typedef logic [CLASS_W-1:0] byte_class_t;
  typedef logic [STATE_W-1:0] dfa_state_t;

  // One classified byte as it waits in the queue
  typedef struct packed {
    byte_class_t             cls;
    logic [BYTE_W-1:0]       data_byte;
    logic                    resync;
  } u8d_item_t;

  // Next-state table, row = state, column = class
  localparam dfa_state_t NEXT_STATE_ROM [ROM_DEPTH] = '{
    4'd0,4'd1,4'd2,4'd3,4'd5,4'd8,4'd7,4'd1,4'd1,4'd1,4'd4,4'd6,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd0,4'd1,4'd0,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd2,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd3,4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,
    4'd1,4'd3,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1,4'd1
  };

  // Byte class table, written as ranges
  function automatic byte_class_t classify_byte(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    c = 4'd8;
    priority if (b <= 8'h7f) c = 4'd0;
    else if (b <= 8'h8f)     c = 4'd1;
    else if (b <= 8'h9f)     c = 4'd9;
    else if (b <= 8'hbf)     c = 4'd7;
    else if (b <= 8'hc1)     c = 4'd8;
    else if (b <= 8'hdf)     c = 4'd2;
    else if (b == 8'he0)     c = 4'd10;
    else if (b == 8'hed)     c = 4'd4;
    else if (b <= 8'hef)     c = 4'd3;
    else if (b == 8'hf0)     c = 4'd11;
    else if (b <= 8'hf3)     c = 4'd6;
    else if (b == 8'hf4)     c = 4'd5;
    else                     c = 4'd8;
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/u8d_if.sv @@
// Channel interfaces: byte input and decoded result output.
`default_nettype none
interface u8d_in_if import u8d_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              resync;

  modport source (output valid, output data_byte, output resync, input ready);
  modport sink   (input valid, input data_byte, input resync, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*;;
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] dfa_state;
  logic [CODE_W-1:0]  code_point;
  logic               char_done;
  logic               bad_sequence;

  modport source (output valid, output dfa_state, output code_point,
                  output char_done, output bad_sequence, input ready);
  modport sink   (input valid, input dfa_state, input code_point,
                  input char_done, input bad_sequence, output ready);
endinterface
`default_nettype wire

@@ hdl/utf8_stream_decoder_top.sv @@
// Top level of the UTF-8 stream decoder.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  in_ch    | sink      | data_byte[7:0], resync
//  out_ch   | source    | dfa_state[3:0], code_point[20:0], char_done, bad_sequence
//
// One byte per clock sustained while out_ch does not stall; each byte taken passes the queue,
// then the result register, before its result is offered on out_ch.
// Synchronous active-low reset empties the queue and puts the decoder in accept state.
// The result register frees as it is taken, so a new byte is decoded in the same cycle;
// while out_ch stalls, the queue absorbs up to QUEUE_DEPTH bytes before in_ch.ready drops.
`default_nettype none
module utf8_stream_decoder_top import u8d_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);

  logic       push_valid, push_ready;
  u8d_item_t  push_item;
  logic       pop_valid, pop_ready;
  u8d_item_t  pop_item;

  u8d_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  u8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  u8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

@@ hdl/u8d_front.sv @@
// Front end: takes input bytes and tags each with its character class.
`default_nettype none
module u8d_front import u8d_pkg::*; (
  u8d_in_if.sink     in_ch,
  output logic       push_valid,
  output u8d_item_t  push_item,
  input  logic       push_ready
);

  assign push_valid          = in_ch.valid;
  assign in_ch.ready         = push_ready;
  assign push_item.cls       = classify_byte(in_ch.data_byte);
  assign push_item.data_byte = in_ch.data_byte;
  assign push_item.resync    = in_ch.resync;

endmodule
`default_nettype wire

@@ hdl/u8d_fifo.sv @@
// Small queue of classified bytes between front and back end.
`default_nettype none
module u8d_fifo import u8d_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  u8d_item_t  push_item,
  output logic       push_ready,
  output logic       pop_valid,
  output u8d_item_t  pop_item,
  input  logic       pop_ready
);

  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8d_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `U8D_ASSERT_HOLDS(a_count_bound, count_r <= CNT_W'(DEPTH))
  `U8D_ASSERT_NEXT(a_push_only_grows, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule
`default_nettype wire

@@ hdl/u8d_back.sv @@
// Back end: DFA step, code point update and result register.
`default_nettype none
module u8d_back import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  u8d_item_t  pop_item,
  output logic       pop_ready,
  u8d_out_if.source  out_ch
);

  `include "assert_macros.svh"

  dfa_state_t         state_r, state_nxt;
  logic [CODE_W-1:0]  partial_r, partial_nxt;
  logic               out_valid_r;
  dfa_state_t         cur_state;
  logic [BYTE_W-1:0]  lead_mask;
  logic               pop;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    cur_state = pop_item.resync ? ST_ACCEPT : state_r;
    if (cur_state >= STATE_W'(STATE_COUNT)) begin
      cur_state = ST_REJECT;
    end
    lead_mask = 8'hff >> pop_item.cls;
    if (cur_state == ST_ACCEPT) begin
      partial_nxt = {{(CODE_W-BYTE_W){1'b0}}, lead_mask & pop_item.data_byte};
    end else begin
      partial_nxt = {partial_r[CODE_W-TRAIL_W-1:0], pop_item.data_byte[TRAIL_W-1:0]};
    end
    state_nxt = NEXT_STATE_ROM[ROM_IDX_W'({cur_state, pop_item.cls})];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        state_r     <= state_nxt;
        partial_r   <= partial_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dfa_state    = state_r;
  assign out_ch.code_point   = partial_r;
  assign out_ch.char_done    = (state_r == ST_ACCEPT);
  assign out_ch.bad_sequence = (state_r == ST_REJECT);

  `U8D_ASSERT_HOLDS(a_state_range, state_r < STATE_W'(STATE_COUNT))
  `U8D_ASSERT_NEXT(a_reject_sticky, pop && !pop_item.resync && state_r == ST_REJECT,
                   state_r == ST_REJECT)
  `U8D_ASSERT_IMPL(a_no_pop_on_stall, out_valid_r && !out_ch.ready, !pop)

endmodule
`default_nettype wire

@@ test/utf8_stream_decoder_top_tb.sv @@
// Testbench for utf8_stream_decoder_top: byte streams in, results checked against a predictor.
module utf8_stream_decoder_top_tb import u8d_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // byte classes
  localparam byte_class_t CL_ASCII   = 4'd0;
  localparam byte_class_t CL_CONT_LO = 4'd1;
  localparam byte_class_t CL_LEAD2   = 4'd2;
  localparam byte_class_t CL_LEAD3   = 4'd3;
  localparam byte_class_t CL_ED      = 4'd4;
  localparam byte_class_t CL_F4      = 4'd5;
  localparam byte_class_t CL_F1_F3   = 4'd6;
  localparam byte_class_t CL_CONT_HI = 4'd7;
  localparam byte_class_t CL_INVALID = 4'd8;
  localparam byte_class_t CL_CONT_MD = 4'd9;
  localparam byte_class_t CL_E0      = 4'd10;
  localparam byte_class_t CL_F0      = 4'd11;

  // mid-sequence states
  localparam dfa_state_t S_TAIL1 = 4'd2;
  localparam dfa_state_t S_TAIL2 = 4'd3;
  localparam dfa_state_t S_E0    = 4'd4;
  localparam dfa_state_t S_ED    = 4'd5;
  localparam dfa_state_t S_F0    = 4'd6;
  localparam dfa_state_t S_F1_F3 = 4'd7;
  localparam dfa_state_t S_F4    = 4'd8;

  localparam int RANDOM_BYTES = 450;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              resync;
  } byte_xfer_t;

  typedef struct packed {
    dfa_state_t        dfa_state;
    logic [CODE_W-1:0] code_point;
    logic              char_done;
    logic              bad_sequence;
  } decoded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_stream_decoder_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_xfer_t        pending_bytes[$];
  decoded_t          expected_results[$];
  dfa_state_t        dec_state = ST_ACCEPT;
  logic [CODE_W-1:0] partial_cp = '0;

  int   error_count = 0;
  int   bytes_taken = 0;
  int   total_bytes = 0;
  int   directed_bytes = 0;
  int   results_checked = 0;
  int   chars_done = 0;
  int   reject_results = 0;
  int   resync_count = 0;

  logic       in_fired = 1'b0;
  int         in_gap = 0;
  int         in_calm = 0;
  int         out_stall = 0;
  int         out_calm = 0;
  byte_xfer_t next_xfer;
  decoded_t   want;

  function automatic byte_class_t class_of(input logic [BYTE_W-1:0] b);
    byte_class_t c;
    case (b[7:4])
      4'h8:       c = CL_CONT_LO;
      4'h9:       c = CL_CONT_MD;
      4'ha, 4'hb: c = CL_CONT_HI;
      4'hc:       c = (b[3:1] == 3'b000) ? CL_INVALID : CL_LEAD2;
      4'hd:       c = CL_LEAD2;
      4'he:       c = (b[3:0] == 4'h0) ? CL_E0 : (b[3:0] == 4'hd) ? CL_ED : CL_LEAD3;
      4'hf: begin
        case (b[3:0])
          4'h0:             c = CL_F0;
          4'h1, 4'h2, 4'h3: c = CL_F1_F3;
          4'h4:             c = CL_F4;
          default:          c = CL_INVALID;
        endcase
      end
      default:    c = CL_ASCII;
    endcase
    return c;
  endfunction

  function automatic dfa_state_t step_state(input dfa_state_t s, input byte_class_t c);
    dfa_state_t n;
    logic       lo, md, hi;
    lo = (c == CL_CONT_LO);
    md = (c == CL_CONT_MD);
    hi = (c == CL_CONT_HI);
    n  = ST_REJECT;
    case (s)
      ST_ACCEPT: begin
        case (c)
          CL_ASCII: n = ST_ACCEPT;
          CL_LEAD2: n = S_TAIL1;
          CL_LEAD3: n = S_TAIL2;
          CL_ED:    n = S_ED;
          CL_F4:    n = S_F4;
          CL_F1_F3: n = S_F1_F3;
          CL_E0:    n = S_E0;
          CL_F0:    n = S_F0;
          default:  n = ST_REJECT;
        endcase
      end
      S_TAIL1: if (lo || md || hi) n = ST_ACCEPT;
      S_TAIL2: if (lo || md || hi) n = S_TAIL1;
      S_E0:    if (hi) n = S_TAIL1;
      S_ED:    if (lo || md) n = S_TAIL1;
      S_F0:    if (md || hi) n = S_TAIL2;
      S_F1_F3: if (lo || md || hi) n = S_TAIL2;
      S_F4:    if (lo) n = S_TAIL2;
      default: n = ST_REJECT;
    endcase
    return n;
  endfunction

  function automatic decoded_t decode_byte(input logic [BYTE_W-1:0] b, input logic rs);
    byte_class_t c;
    decoded_t    r;
    c = class_of(b);
    if (rs)
      dec_state = ST_ACCEPT;
    if (dec_state == ST_ACCEPT)
      partial_cp = CODE_W'((8'hff >> c) & b);
    else
      partial_cp = {partial_cp[CODE_W-7:0], b[5:0]};
    dec_state      = step_state(dec_state, c);
    r.dfa_state    = dec_state;
    r.code_point   = partial_cp;
    r.char_done    = (dec_state == ST_ACCEPT);
    r.bad_sequence = (dec_state == ST_REJECT);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic rs);
    byte_xfer_t x;
    x.data_byte = b;
    x.resync    = rs;
    pending_bytes.push_back(x);
  endtask

  task automatic push_char(input logic [20:0] cp, input logic rs);
    if (cp < 21'h80) begin
      push_byte(cp[7:0], rs);
    end else if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]}, rs);
      push_byte({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]}, rs);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      push_byte({5'b11110, cp[20:18]}, rs);
      push_byte({2'b10, cp[17:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  function automatic logic [20:0] random_char();
    logic [20:0] cp;
    case ($urandom_range(1, 4))
      1: cp = 21'($urandom_range(0, 'h7f));
      2: cp = 21'($urandom_range('h80, 'h7ff));
      3: begin
        cp = 21'($urandom_range('h800, 'hffff));
        while (cp >= 21'hd800 && cp <= 21'hdfff)
          cp = 21'($urandom_range('h800, 'hffff));
      end
      default: cp = 21'($urandom_range('h10000, 'h10ffff));
    endcase
    return cp;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return 0;
    else if (r < 88)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 30);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (in_gap > 0 || pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0)
          in_gap--;
      end else begin
        next_xfer = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= next_xfer.data_byte;
        in_ch.resync    <= next_xfer.resync;
        if (in_calm > 0) begin
          in_calm--;
          in_gap = 0;
        end else if ($urandom_range(0, 24) == 0) begin
          in_calm = $urandom_range(20, 60);
          in_gap  = 0;
        end else begin
          in_gap = draw_gap();
        end
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_calm > 0)
        out_calm--;
      else if ($urandom_range(0, 24) == 0)
        out_calm = $urandom_range(20, 60);
      else if ($urandom_range(0, 2) == 0)
        out_stall = draw_gap();
    end
  end

  // monitor: predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(decode_byte(in_ch.data_byte, in_ch.resync));
        bytes_taken++;
        if (in_ch.resync)
          resync_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no byte outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_ch.dfa_state !== want.dfa_state)
            report_mismatch($sformatf("result %0d dfa_state got %0d want %0d",
                                      results_checked, out_ch.dfa_state, want.dfa_state));
          if (out_ch.code_point !== want.code_point)
            report_mismatch($sformatf("result %0d code_point got 0x%06h want 0x%06h",
                                      results_checked, out_ch.code_point, want.code_point));
          if (out_ch.char_done !== want.char_done)
            report_mismatch($sformatf("result %0d char_done got %b want %b",
                                      results_checked, out_ch.char_done, want.char_done));
          if (out_ch.bad_sequence !== want.bad_sequence)
            report_mismatch($sformatf("result %0d bad_sequence got %b want %b",
                                      results_checked, out_ch.bad_sequence,
                                      want.bad_sequence));
          if (want.char_done)
            chars_done++;
          if (want.bad_sequence)
            reject_results++;
          results_checked++;
        end
      end
    end
  end

  initial begin
    int          r;
    int          k;
    int          len;
    logic        dirty;

    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.resync    = 1'b0;
    out_ch.ready    = 1'b0;

    // directed: field extremes, each sequence shape, reject and resync paths
    push_byte(8'h00, 1'b0);
    push_char(21'h80, 1'b0);
    push_char(21'h800, 1'b0);
    push_char(21'hd7ff, 1'b0);
    push_char(21'h10000, 1'b0);
    push_char(21'h10ffff, 1'b0);
    push_byte(8'h80, 1'b0);          // lone continuation
    push_byte(8'hff, 1'b0);          // stays rejected, code keeps shifting
    push_byte(8'hbf, 1'b0);
    push_byte(8'hc0, 1'b1);          // overlong lead
    push_byte(8'he0, 1'b1);
    push_byte(8'h80, 1'b0);          // overlong three-byte form
    push_byte(8'hf4, 1'b1);
    push_byte(8'h90, 1'b0);          // above U+10FFFF
    push_byte(8'h41, 1'b1);
    directed_bytes = pending_bytes.size();

    dirty = 1'b1;
    while (pending_bytes.size() < directed_bytes + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        push_char(random_char(), dirty || ($urandom_range(0, 9) == 0));
        dirty = 1'b0;
      end else if (r < 86) begin
        // truncated sequence, resync may land on a continuation
        len = $urandom_range(2, 4);
        case (len)
          2:       push_byte({3'b110, 5'($urandom)}, 1'($urandom_range(0, 1)));
          3:       push_byte({4'b1110, 4'($urandom)}, 1'($urandom_range(0, 1)));
          default: push_byte({5'b11110, 3'($urandom)}, 1'($urandom_range(0, 1)));
        endcase
        k = $urandom_range(0, len - 2);
        repeat (k)
          push_byte({2'b10, 6'($urandom)}, $urandom_range(0, 3) == 0);
        dirty = 1'b1;
      end else begin
        k = $urandom_range(1, 4);
        repeat (k)
          push_byte(8'($urandom), $urandom_range(0, 3) == 0);
        dirty = 1'b1;
      end
    end
    total_bytes = pending_bytes.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("run covered %0d bytes (%0d directed), %0d results checked",
             total_bytes, directed_bytes, results_checked);
    $display("%0d characters completed, %0d rejected results, %0d resync transfers",
             chars_done, reject_results, resync_count);
    if (error_count == 0)
      $display("utf8_stream_decoder_top verification clean");
    else
      $display("utf8_stream_decoder_top verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
             bytes_taken, total_bytes, expected_results.size());
    $display("utf8_stream_decoder_top verification failed");
    $finish;
  end

endmodule
